// File: src/mrfr_pkg.sv
// Shared types and constants for the Modbus RTU request frame receiver.
// No dependencies; the receiver and the checker refer to this package.
package mrfr_pkg;

  // Frame buffer size in bytes (16 to 256). The position counter is sized from it.
  localparam int unsigned FRAME_BUFFER_BYTES = 256;
  localparam int unsigned POS_W              = $clog2(FRAME_BUFFER_BYTES);

  typedef logic [POS_W-1:0] pos_t;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR = 1'b0,
    CFG_BCAST_ADDR = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;
  localparam logic [7:0] BCAST_ADDR_RST = 8'h00;

  // Input operation codes.
  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  // Request kinds as reported on frame_kind.
  typedef enum logic [1:0] {
    KIND_NONE       = 2'd0,
    KIND_READ_REGS  = 2'd1,
    KIND_WRITE_REG  = 2'd2,
    KIND_WRITE_REGS = 2'd3
  } kind_e;

  // Function codes.
  localparam logic [7:0] FC_READ_REGS  = 8'h03;
  localparam logic [7:0] FC_WRITE_REG  = 8'h06;
  localparam logic [7:0] FC_WRITE_REGS = 8'h10;

  // Byte positions within the frame.
  localparam pos_t POS_ADDR      = pos_t'(0);
  localparam pos_t POS_FUNC      = pos_t'(1);
  localparam pos_t POS_COUNT     = pos_t'(6);
  localparam pos_t POS_FIXED_END = pos_t'(7);

  // A multi-register write ends at byte count plus this offset.
  localparam logic [8:0] MULTI_END_OFFSET = 9'd8;

  // One result transaction.
  typedef struct packed {
    logic       byte_accepted;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    kind_e      frame_kind;
    logic       frame_complete;
    logic       frame_dropped;
  } result_t;

endpackage

// File: src/mrfr_if.sv
// Valid/ready channel interfaces for the frame receiver: received bytes in,
// per-byte results out. Plain widths only; no package dependency.
interface mrfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mrfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_accepted;
  logic [7:0] byte_index;
  logic [7:0] byte_value;
  logic [1:0] frame_kind;
  logic       frame_complete;
  logic       frame_dropped;

  modport source (output valid, output byte_accepted, output byte_index,
                  output byte_value, output frame_kind, output frame_complete,
                  output frame_dropped, input ready);
  modport sink   (input valid, input byte_accepted, input byte_index,
                  input byte_value, input frame_kind, input frame_complete,
                  input frame_dropped, output ready);
endinterface

// File: src/modbus_rtu_frame_receiver.sv
// Registered output; a result appears in the output register the cycle after its input.
// Throughput: one transaction per cycle; input ready drops only while a result
//   waits in the output register and the sink is not ready.
// Reset (rst_ni low, asynchronous): position, request kind, byte count and held
//   flag clear, slave address returns to 1, broadcast address to 0, output empties.
// Depends on mrfr_pkg and the interfaces in mrfr_if.sv.
module modbus_rtu_frame_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mrfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mrfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mrfr_in_if.sink                         in_i,
  mrfr_out_if.source                      out_o
);

  // Configuration registers
  logic [7:0] slave_addr_q;
  logic [7:0] bcast_addr_q;

  // Frame state
  mrfr_pkg::pos_t  pos_q,  pos_d;
  mrfr_pkg::kind_e kind_q, kind_d;
  logic [7:0]      cnt_q,  cnt_d;
  logic            held_q, held_d;

  // Output register
  logic              out_valid_q;
  mrfr_pkg::result_t res_q, res_d;

  logic                     in_fire;
  logic [mrfr_pkg::POS_W:0] pos_inc;
  mrfr_pkg::kind_e          fc_kind;
  logic                     addr_match;
  logic                     acc, cmp, drop, skip;
  mrfr_pkg::kind_e          kind_out;

  // Take a new transaction whenever the output register is free or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Configuration writes; index 0 sets the slave address, index 1 the broadcast address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mrfr_pkg::SLAVE_ADDR_RST;
      bcast_addr_q <= mrfr_pkg::BCAST_ADDR_RST;
    end else if (cfg_we_i) begin
      unique case (mrfr_pkg::cfg_idx_e'(cfg_index_i))
        mrfr_pkg::CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i;
        mrfr_pkg::CFG_BCAST_ADDR: bcast_addr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Function code decode.
  always_comb begin
    unique case (in_i.rx_byte)
      mrfr_pkg::FC_READ_REGS:  fc_kind = mrfr_pkg::KIND_READ_REGS;
      mrfr_pkg::FC_WRITE_REG:  fc_kind = mrfr_pkg::KIND_WRITE_REG;
      mrfr_pkg::FC_WRITE_REGS: fc_kind = mrfr_pkg::KIND_WRITE_REGS;
      default:                 fc_kind = mrfr_pkg::KIND_NONE;
    endcase
  end

  assign addr_match = (in_i.rx_byte == slave_addr_q) || (in_i.rx_byte == bcast_addr_q);
  assign pos_inc    = {1'b0, pos_q} + {{mrfr_pkg::POS_W{1'b0}}, 1'b1};

  // One pass over the incoming byte: classify, advance position, build the result.
  always_comb begin
    pos_d    = pos_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    acc      = 1'b0;
    cmp      = 1'b0;
    drop     = 1'b0;
    skip     = 1'b0;
    kind_out = mrfr_pkg::KIND_NONE;

    if (mrfr_pkg::op_e'(in_i.operation) == mrfr_pkg::OP_RESTART) begin
      // Restart: discard any partial frame and release a held one.
      pos_d  = '0;
      held_d = 1'b0;
      kind_d = mrfr_pkg::KIND_NONE;
    end else if (held_q) begin
      // Hold the completed frame; ignore the byte.
      skip = 1'b1;
    end else begin
      if (pos_q == mrfr_pkg::POS_ADDR) begin
        if (addr_match) begin
          kind_d = mrfr_pkg::KIND_NONE;
          acc    = 1'b1;
        end else begin
          skip = 1'b1;
        end
      end else if (pos_q == mrfr_pkg::POS_FUNC) begin
        kind_d = fc_kind;
        if (fc_kind == mrfr_pkg::KIND_NONE) begin
          drop = 1'b1;
        end else begin
          acc      = 1'b1;
          kind_out = fc_kind;
        end
      end else if (kind_q == mrfr_pkg::KIND_NONE) begin
        drop = 1'b1;
      end else begin
        acc      = 1'b1;
        kind_out = kind_q;
        if (pos_q == mrfr_pkg::POS_COUNT) begin
          cnt_d = in_i.rx_byte;
        end
        // Byte count is stored before any position that can end the frame.
        if (kind_q == mrfr_pkg::KIND_WRITE_REGS) begin
          cmp = (pos_q >= mrfr_pkg::POS_FIXED_END) &&
                (9'(pos_q) == ({1'b0, cnt_q} + mrfr_pkg::MULTI_END_OFFSET));
        end else begin
          cmp = (pos_q == mrfr_pkg::POS_FIXED_END);
        end
      end

      if (drop) begin
        pos_d  = '0;
        kind_d = mrfr_pkg::KIND_NONE;
      end else if (!skip) begin
        if (pos_inc >= (mrfr_pkg::POS_W+1)'(mrfr_pkg::FRAME_BUFFER_BYTES)) begin
          // Buffer end: a completing byte still counts, anything else overflows.
          pos_d = '0;
          if (!cmp) begin
            drop     = 1'b1;
            acc      = 1'b0;
            kind_out = mrfr_pkg::KIND_NONE;
            kind_d   = mrfr_pkg::KIND_NONE;
          end
        end else begin
          pos_d = pos_inc[mrfr_pkg::POS_W-1:0];
        end
        if (cmp) begin
          held_d = 1'b1;
        end
      end
    end

    res_d                = '0;
    res_d.frame_complete = cmp;
    res_d.frame_dropped  = drop;
    if (acc) begin
      res_d.byte_accepted = 1'b1;
      res_d.byte_index    = 8'(pos_q);
      res_d.byte_value    = in_i.rx_byte;
      res_d.frame_kind    = kind_out;
    end
  end

  // Frame state advances only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= mrfr_pkg::KIND_NONE;
      cnt_q  <= '0;
      held_q <= 1'b0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

  // Output register: load on input transaction, drain when the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.byte_accepted  = res_q.byte_accepted;
  assign out_o.byte_index     = res_q.byte_index;
  assign out_o.byte_value     = res_q.byte_value;
  assign out_o.frame_kind     = res_q.frame_kind;
  assign out_o.frame_complete = res_q.frame_complete;
  assign out_o.frame_dropped  = res_q.frame_dropped;

endmodule

// File: src/mrfr_checker.sv
// Port-level checks for the frame receiver, attached by bind.
// Depends on mrfr_pkg and the top level modbus_rtu_frame_receiver.
module mrfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       byte_accepted_i,
  input logic [7:0] byte_index_i,
  input logic [7:0] byte_value_i,
  input logic [1:0] frame_kind_i,
  input logic       frame_complete_i,
  input logic       frame_dropped_i
);

  // Hold a stalled result unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_accepted_i) &&
      $stable(byte_index_i) && $stable(byte_value_i) && $stable(frame_kind_i) &&
      $stable(frame_complete_i) && $stable(frame_dropped_i))
    else $error("stalled result changed");

  // A rejected byte reports zero index, value and kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_accepted_i |->
      byte_index_i == 8'd0 && byte_value_i == 8'd0 &&
      frame_kind_i == mrfr_pkg::KIND_NONE)
    else $error("rejected byte carries payload");

  // Completion only on an accepted, classified, undropped byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_complete_i |->
      byte_accepted_i && !frame_dropped_i && frame_kind_i != mrfr_pkg::KIND_NONE)
    else $error("bad completion");

  // Address byte has no kind; every later accepted byte has one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_accepted_i |->
      ((byte_index_i == 8'd0) == (frame_kind_i == mrfr_pkg::KIND_NONE)))
    else $error("kind does not match index");

endmodule

bind modbus_rtu_frame_receiver mrfr_checker u_mrfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .byte_accepted_i  (out_o.byte_accepted),
  .byte_index_i     (out_o.byte_index),
  .byte_value_i     (out_o.byte_value),
  .frame_kind_i     (out_o.frame_kind),
  .frame_complete_i (out_o.frame_complete),
  .frame_dropped_i  (out_o.frame_dropped)
);
